### rtl/mftt_pkg.sv
package mftt_pkg;

    // Encoder resolution and turn detection threshold
    localparam int COUNTS_PER_REV = 8192;
    localparam int HALF_REV       = COUNTS_PER_REV / 2;

    // Field widths
    localparam int TOTAL_W  = 32;
    localparam int POS_W    = 16;
    localparam int WORD_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 21;
    localparam int REQ_W    = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_FRAME = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ZERO  = 2'd2;

    // One result word
    typedef struct packed {
        logic signed [TOTAL_W-1:0] total_count;
        logic signed [WORD_W-1:0]  speed_rpm;
        logic signed [WORD_W-1:0]  current_raw;
        logic [BYTE_W-1:0]         temperature_c;
        logic                      online;
    } t_result;

endpackage

### rtl/mftt_tracker.sv
module mftt_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [mftt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [mftt_pkg::BYTE_W-1:0]    i_pos_hi,
    input  logic [mftt_pkg::BYTE_W-1:0]    i_pos_lo,
    input  logic [mftt_pkg::BYTE_W-1:0]    i_speed_hi,
    input  logic [mftt_pkg::BYTE_W-1:0]    i_speed_lo,
    input  logic [mftt_pkg::BYTE_W-1:0]    i_cur_hi,
    input  logic [mftt_pkg::BYTE_W-1:0]    i_cur_lo,
    input  logic [mftt_pkg::BYTE_W-1:0]    i_temp_byte,
    input  logic [mftt_pkg::OFFSET_W-1:0]  i_offset,
    output mftt_pkg::t_result              o_result
);
    import mftt_pkg::*;

    localparam logic signed [POS_W+1:0] HALF_S = (POS_W+2)'(HALF_REV);

    logic [POS_W-1:0]   r_last_pos,   n_last_pos;
    logic [TOTAL_W-1:0] r_turn,       n_turn;
    logic [POS_W-1:0]   r_zero_ref,   n_zero_ref;
    logic               r_zero_pend,  n_zero_pend;
    logic               r_frame_seen, n_frame_seen;
    logic               r_online,     n_online;
    logic [WORD_W-1:0]  r_speed,      n_speed;
    logic [WORD_W-1:0]  r_cur,        n_cur;
    logic [BYTE_W-1:0]  r_temp,       n_temp;
    logic [TOTAL_W-1:0] r_total,      n_total;

    logic [POS_W-1:0]          w_pos;
    logic [POS_W-1:0]          w_delta;
    logic signed [POS_W+1:0]   w_delta_ext;
    logic [TOTAL_W-1:0]        w_frame_turn;
    logic [POS_W-1:0]          w_frame_ref;
    logic [TOTAL_W-1:0]        w_offs_ext;
    logic [TOTAL_W-1:0]        w_frame_total;

    // Position delta against the previous frame, as signed 16-bit
    assign w_pos       = {i_pos_hi, i_pos_lo};
    assign w_delta     = w_pos - r_last_pos;
    assign w_delta_ext = $signed({{2{w_delta[POS_W-1]}}, w_delta});

    // Turn count and reference that a frame leaves behind
    always_comb begin
        w_frame_turn = r_turn;
        w_frame_ref  = r_zero_ref;
        if (r_zero_pend) begin
            w_frame_turn = '0;
            w_frame_ref  = w_pos;
        end else if (w_delta_ext < -HALF_S) begin
            w_frame_turn = r_turn + 32'd1;
        end else if (w_delta_ext > HALF_S) begin
            w_frame_turn = r_turn - 32'd1;
        end
    end

    // Multi-turn count, wraps modulo 2^32
    assign w_offs_ext    = {{(TOTAL_W-OFFSET_W){i_offset[OFFSET_W-1]}}, i_offset};
    assign w_frame_total = w_frame_turn * TOTAL_W'(COUNTS_PER_REV)
                         + TOTAL_W'(w_pos) + w_offs_ext - TOTAL_W'(w_frame_ref);

    // Request decode and state update
    always_comb begin
        n_last_pos   = r_last_pos;
        n_turn       = r_turn;
        n_zero_ref   = r_zero_ref;
        n_zero_pend  = r_zero_pend;
        n_frame_seen = r_frame_seen;
        n_online     = r_online;
        n_speed      = r_speed;
        n_cur        = r_cur;
        n_temp       = r_temp;
        n_total      = r_total;
        if (i_accept) begin
            unique case (i_req_type)
                REQ_FRAME: begin
                    n_last_pos   = w_pos;
                    n_turn       = w_frame_turn;
                    n_zero_ref   = w_frame_ref;
                    n_zero_pend  = 1'b0;
                    n_frame_seen = 1'b1;
                    n_speed      = {i_speed_hi, i_speed_lo};
                    n_cur        = {i_cur_hi, i_cur_lo};
                    n_temp       = i_temp_byte;
                    n_total      = w_frame_total;
                end
                REQ_TICK: begin
                    n_online     = r_frame_seen;
                    n_frame_seen = 1'b0;
                end
                REQ_ZERO: begin
                    n_zero_pend  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos   <= '0;
            r_turn       <= '0;
            r_zero_ref   <= '0;
            r_zero_pend  <= 1'b0;
            r_frame_seen <= 1'b0;
            r_online     <= 1'b0;
            r_speed      <= '0;
            r_cur        <= '0;
            r_temp       <= '0;
            r_total      <= '0;
        end else begin
            r_last_pos   <= n_last_pos;
            r_turn       <= n_turn;
            r_zero_ref   <= n_zero_ref;
            r_zero_pend  <= n_zero_pend;
            r_frame_seen <= n_frame_seen;
            r_online     <= n_online;
            r_speed      <= n_speed;
            r_cur        <= n_cur;
            r_temp       <= n_temp;
            r_total      <= n_total;
        end
    end

    // Result word carries the updated held values
    always_comb begin
        o_result.total_count   = $signed(n_total);
        o_result.speed_rpm     = $signed(n_speed);
        o_result.current_raw   = $signed(n_cur);
        o_result.temperature_c = n_temp;
        o_result.online        = n_online;
    end

`ifndef ASSERT_OFF
    // A frame with a zero pending restarts the turn count
    a_zero_clears_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_req_type == REQ_FRAME && r_zero_pend
        |=> r_turn == '0 && !r_zero_pend && r_zero_ref == $past(w_pos))
        else $error("zero request did not clear turn count");

    // A tick clears the frame flag and latches it as online
    a_tick_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_req_type == REQ_TICK
        |=> !r_frame_seen && r_online == $past(r_frame_seen))
        else $error("alive tick did not latch online flag");

    // Turn count moves by at most one per cycle
    a_turn_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(r_zero_pend) && $past(i_rst_n)
        |-> r_turn == $past(r_turn) || r_turn == $past(r_turn) + 32'd1
            || r_turn == $past(r_turn) - 32'd1)
        else $error("turn count jumped");
`endif

endmodule

### rtl/mftt_out_queue.sv
module mftt_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mftt_pkg::t_result  i_word,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output mftt_pkg::t_result  o_word
);
    import mftt_pkg::*;

    logic    r_head_valid, n_head_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_head,       n_head;
    t_result r_skid,       n_skid;
    logic    w_pop;

    assign w_pop   = r_head_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_word  = r_head;

    // Two-entry queue: head drives the port, skid catches a word while head stalls
    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (!r_head_valid || w_pop) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_head_valid = 1'b1;
                n_skid_valid = 1'b0;
                if (i_push) begin
                    n_skid       = i_word;
                    n_skid_valid = 1'b1;
                end
            end else begin
                n_head       = i_word;
                n_head_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_word;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

`ifndef ASSERT_OFF
    // Skid only holds a word behind a valid head
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid valid without head");

    // No push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("push into full queue");

    // A stalled head with a push fills the skid
    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_valid && i_stall && i_push |=> r_skid_valid && r_skid == $past(i_word))
        else $error("word lost under stall");
`endif

endmodule

### rtl/motor_feedback_turn_tracker_unit.sv
// A result word is formed combinationally from its accepted request word and is registered in
// a two-entry output queue. One word is accepted per cycle while the queue is not full; the
// queue lets input keep flowing for one extra word while the output is stalled.
// Reset (i_rst_n, synchronous, active low): all tracking state, held values and the
// encoder offset clear to zero, online reads offline, and the output queue empties.
module motor_feedback_turn_tracker_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [mftt_pkg::REQ_W-1:0]           i_req_type,
    input  logic [mftt_pkg::BYTE_W-1:0]          i_pos_hi,
    input  logic [mftt_pkg::BYTE_W-1:0]          i_pos_lo,
    input  logic [mftt_pkg::BYTE_W-1:0]          i_speed_hi,
    input  logic [mftt_pkg::BYTE_W-1:0]          i_speed_lo,
    input  logic [mftt_pkg::BYTE_W-1:0]          i_cur_hi,
    input  logic [mftt_pkg::BYTE_W-1:0]          i_cur_lo,
    input  logic [mftt_pkg::BYTE_W-1:0]          i_temp_byte,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [mftt_pkg::TOTAL_W-1:0]  o_total_count,
    output logic signed [mftt_pkg::WORD_W-1:0]   o_speed_rpm,
    output logic signed [mftt_pkg::WORD_W-1:0]   o_current_raw,
    output logic [mftt_pkg::BYTE_W-1:0]          o_temperature_c,
    output logic                                 o_online,
    // config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mftt_pkg::OFFSET_W-1:0]        i_cfg_data
);
    import mftt_pkg::*;

    logic [OFFSET_W-1:0] r_offset;
    logic                w_accept;
    logic                w_full;
    t_result             w_result;
    t_result             w_out_word;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;
    assign w_accept    = i_in_valid && !w_full;

    // Encoder offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_offset <= i_cfg_data;
        end
    end

    mftt_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_req_type  (i_req_type),
        .i_pos_hi    (i_pos_hi),
        .i_pos_lo    (i_pos_lo),
        .i_speed_hi  (i_speed_hi),
        .i_speed_lo  (i_speed_lo),
        .i_cur_hi    (i_cur_hi),
        .i_cur_lo    (i_cur_lo),
        .i_temp_byte (i_temp_byte),
        .i_offset    (r_offset),
        .o_result    (w_result)
    );

    mftt_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_word  (w_result),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (w_out_word)
    );

    // Result fields
    assign o_total_count   = w_out_word.total_count;
    assign o_speed_rpm     = w_out_word.speed_rpm;
    assign o_current_raw   = w_out_word.current_raw;
    assign o_temperature_c = w_out_word.temperature_c;
    assign o_online        = w_out_word.online;

endmodule
